@@ design/fprt_pkg.sv @@
// Shared types and constants for the frame pacing release timer.
// Used by fprt_div and frame_pacing_release_timer; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fprt_pkg;

  localparam int TIME_W  = 63;   // tick count width
  localparam int TGT_W   = 64;   // target register wraps mod 2^64
  localparam int FREQ_W  = 32;
  localparam int RATE_W  = 10;
  localparam int MULT_W  = 4;
  localparam int DVS_W   = 13;   // capture_rate * multiplier <= 8184
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W   = 32;
  localparam int DIV_CNT_W = $clog2(FREQ_W);   // divider step counter

  localparam logic [MULT_W-1:0] MULT_MAX = MULT_W'(8);

  localparam logic [FREQ_W-1:0] TIMER_FREQ_RST = FREQ_W'(10000000);
  localparam logic [MULT_W-1:0] RATE_MULT_RST  = MULT_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMER_FREQ   = 3'd0,
    CFG_SYNC_ENABLE  = 3'd1,
    CFG_CAPTURE_RATE = 3'd2,
    CFG_RATE_MULT    = 3'd3,
    CFG_GENERAL_EN   = 3'd4,
    CFG_GENERAL_RATE = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    MODE_FRAME = 1'b0,
    MODE_RESET = 1'b1
  } mode_t;

  typedef struct packed {
    logic              mode;
    logic [TIME_W-1:0] time_now;
    logic              recording;
  } in_req_t;

  typedef struct packed {
    logic              paced;
    logic [TIME_W-1:0] release_time;
  } out_res_t;

  // Divider request: start pulse with operands.
  typedef struct packed {
    logic              start;
    logic [FREQ_W-1:0] dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FREQ_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ design/frame_pacing_release_timer.sv @@
// Frame pacing release timer: turns frame requests into release ticks on a fixed cadence.
// Depends on fprt_pkg and fprt_div.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one request: mode, time_now,
//   recording. A frame request (mode 0) yields exactly one result on the output channel
//   (out_valid / out_stall / out_data); a timing reset request (mode 1) yields none.
//   Configuration is written through cfg_we / cfg_index / cfg_data while idle.
// Sequence:
//   Paced frame, from accept to out_valid: 32 steps of the shared divider, one to take
//   the quotient, one each for the lag subtract, the compare / re-arm and the target
//   advance, one to load the output register. Unpaced frame: straight to the output load.
//   Timing reset: no result. in_stall is high while a paced or unpaced frame is in work,
//   so a new request is accepted only once that frame has reached the output register.
// Reset:
//   rst (synchronous) restores register defaults and disarms the target.
// Output stall:
//   The result sits in an output register. A new request is accepted while it waits;
//   that request's result is held internally until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module frame_pacing_release_timer (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire fprt_pkg::in_req_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output fprt_pkg::out_res_t                     out_data,
  input  wire logic                              cfg_we,
  input  wire logic [fprt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fprt_pkg::CFG_W-1:0]        cfg_data
);
  import fprt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_DIFF  = 6'b000100,
    S_CHECK = 6'b001000,
    S_ADV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;

  // configuration
  logic [FREQ_W-1:0] timer_freq;
  logic              sync_enable;
  logic [RATE_W-1:0] capture_rate;
  logic [MULT_W-1:0] rate_multiplier;
  logic              general_enable;
  logic [RATE_W-1:0] general_rate;

  // timing state
  logic [TGT_W-1:0]  next_release;
  logic [FREQ_W-1:0] last_interval;

  // per-request work registers
  logic [TIME_W-1:0] now_q;
  logic [FREQ_W-1:0] interval;
  logic [TGT_W:0]    lag;        // {borrow, now - target}
  out_res_t          res;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              accept;
  logic              use_capture;
  logic              active;
  logic [RATE_W+MULT_W-1:0] cap_prod;
  logic [DVS_W-1:0]  divisor;
  logic              mult_ok;
  logic [FREQ_W-1:0] phase;
  logic              late;
  logic              out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    use_capture = in_data.recording && sync_enable;
    cap_prod    = capture_rate * rate_multiplier;
    mult_ok     = (rate_multiplier != '0) && (rate_multiplier <= MULT_MAX);
    if (use_capture) begin
      active  = (capture_rate != '0) && mult_ok;
      divisor = cap_prod[DVS_W-1:0];
    end else begin
      active  = general_enable && (general_rate != '0);
      divisor = DVS_W'(general_rate);
    end
  end

  always_comb begin
    div_req.start    = accept && (in_data.mode == MODE_FRAME) && active;
    div_req.dividend = timer_freq;
    div_req.divisor  = divisor;
  end

  fprt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // half interval, at least one tick
  assign phase = (interval[FREQ_W-1:1] == '0) ? FREQ_W'(1) : {1'b0, interval[FREQ_W-1:1]};
  // late only when now is past the target by more than two intervals
  assign late  = !lag[TGT_W] && (lag[TGT_W-1:0] > {{(TGT_W-FREQ_W-1){1'b0}}, interval, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_freq      <= TIMER_FREQ_RST;
      sync_enable     <= 1'b0;
      capture_rate    <= '0;
      rate_multiplier <= RATE_MULT_RST;
      general_enable  <= 1'b0;
      general_rate    <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TIMER_FREQ:   timer_freq      <= cfg_data[FREQ_W-1:0];
        CFG_SYNC_ENABLE:  sync_enable     <= cfg_data[0];
        CFG_CAPTURE_RATE: capture_rate    <= cfg_data[RATE_W-1:0];
        CFG_RATE_MULT:    rate_multiplier <= cfg_data[MULT_W-1:0];
        CFG_GENERAL_EN:   general_enable  <= cfg_data[0];
        CFG_GENERAL_RATE: general_rate    <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      next_release  <= '0;
      last_interval <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_data.mode == MODE_RESET) begin
              next_release <= '0;
            end else if (active) begin
              state <= S_DIV;
            end else begin
              next_release  <= '0;
              last_interval <= '0;
              state         <= S_OUT;
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (last_interval != '0 && div_rsp.quotient != last_interval) begin
              next_release <= '0;
            end
            last_interval <= div_rsp.quotient;
            state         <= S_DIFF;
          end
        end
        S_DIFF: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (next_release == '0 || late) begin
            next_release <= {1'b0, now_q} + {{(TGT_W-FREQ_W){1'b0}}, phase};
          end
          state <= S_ADV;
        end
        S_ADV: begin
          next_release <= next_release + {{(TGT_W-FREQ_W){1'b0}}, interval};
          state        <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      now_q <= in_data.time_now;
    end
    if (accept && !active) begin
      res.paced        <= 1'b0;
      res.release_time <= in_data.time_now;
    end
    if (state == S_DIV && div_rsp.done) begin
      interval <= div_rsp.quotient;
    end
    if (state == S_DIFF) begin
      lag <= {2'b00, now_q} - {1'b0, next_release};
    end
    if (state == S_ADV) begin
      res.paced        <= 1'b1;
      res.release_time <= next_release[TIME_W-1:0];
    end
    if (state == S_OUT && out_free) begin
      out_data <= res;
    end
  end

  // The divider is only started from an idle block.
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> state == S_IDLE)
    else $error("divider started while busy");

  // A new result appears only out of the output state.
  a_out_from_state: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result raised outside the output state");

  // The advance step moves the target by exactly one interval.
  a_target_advance: assert property (@(posedge clk) disable iff (rst)
    state == S_ADV |=> next_release ==
      $past(next_release) + {{(TGT_W-FREQ_W){1'b0}}, $past(interval)})
    else $error("target not advanced by one interval");

  // Divider completion always moves the sequencer on.
  a_div_done_next: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_rsp.done) |=> state == S_DIFF)
    else $error("divider result not taken");

endmodule

`default_nettype wire

@@ design/fprt_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on fprt_pkg for widths and the request/response structs.
`timescale 1ns / 1ps
`default_nettype none

module fprt_div (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire fprt_pkg::div_req_t req,
  output fprt_pkg::div_rsp_t    rsp
);
  import fprt_pkg::*;

  logic [DVS_W-1:0]     rem;
  logic [FREQ_W-1:0]    quo;
  logic [DVS_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0] count;
  logic                 busy;
  logic                 done;

  logic [DVS_W:0]    shifted;
  logic [DVS_W+1:0]  trial;

  always_comb begin
    shifted = {rem, quo[FREQ_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + DIV_CNT_W'(1);
        if (count == DIV_CNT_W'(FREQ_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      if (!trial[DVS_W+1]) begin
        rem <= trial[DVS_W-1:0];
        quo <= {quo[FREQ_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DVS_W-1:0];
        quo <= {quo[FREQ_W-2:0], 1'b0};
      end
    end
  end

  assign rsp = '{done: done, quotient: quo};

endmodule

`default_nettype wire

@@ test/tb_frame_pacing_release_timer.sv @@
// Testbench for frame_pacing_release_timer: directed and random frame requests, checked
// against a scoreboard that predicts every release tick. Needs fprt_pkg and the design.
`timescale 1ns / 1ps

module tb_frame_pacing_release_timer;
  import fprt_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int CYCLE_LIMIT = 500000;
  localparam int ITEM_TARGET = 1150;
  localparam int SETTLE      = 64;
  localparam int HOLD_CYCLES = 400;
  localparam logic [TIME_W-1:0] TICK_MAX = '1;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic              sync_en;
    logic [RATE_W-1:0] cap_rate;
    logic [MULT_W-1:0] mult;
    logic              gen_en;
    logic [RATE_W-1:0] gen_rate;
  } pacing_cfg_t;

  localparam pacing_cfg_t CFG_DEFAULTS = '{freq: TIMER_FREQ_RST, sync_en: 1'b0,
                                           cap_rate: '0, mult: RATE_MULT_RST,
                                           gen_en: 1'b0, gen_rate: '0};

  class release_scoreboard;
    pacing_cfg_t cfg;
    logic [63:0] target_tick;
    logic [63:0] prev_interval;
    out_res_t    release_q[$];
    int          mismatches;

    function new();
      cfg           = CFG_DEFAULTS;
      target_tick   = '0;
      prev_interval = '0;
      mismatches    = 0;
    endfunction

    function logic [63:0] frame_interval(logic rec, output logic active);
      logic [63:0] divisor;
      active  = 1'b0;
      divisor = 64'd1;
      if (rec && cfg.sync_en) begin
        // invalid capture setup does not fall back to the general limit
        if (cfg.cap_rate != '0 && cfg.mult >= MULT_W'(1) && cfg.mult <= MULT_MAX) begin
          divisor = 64'(cfg.cap_rate) * 64'(cfg.mult);
          active  = 1'b1;
        end
      end else if (cfg.gen_en && cfg.gen_rate != '0) begin
        divisor = 64'(cfg.gen_rate);
        active  = 1'b1;
      end
      return active ? 64'(cfg.freq) / divisor : 64'd0;
    endfunction

    function void note_request(in_req_t req);
      logic [63:0] iv, half, now64, rel;
      logic        active;
      if (req.mode == MODE_RESET) begin
        target_tick = '0;
        return;
      end
      iv    = frame_interval(req.recording, active);
      now64 = {1'b0, req.time_now};
      if (!active) begin
        target_tick   = '0;
        prev_interval = '0;
        release_q.push_back('{paced: 1'b0, release_time: req.time_now});
        return;
      end
      if (prev_interval != '0 && iv != prev_interval)
        target_tick = '0;
      prev_interval = iv;
      half = (iv / 2 == '0) ? 64'd1 : iv / 2;
      // re-arm when disarmed or more than two intervals behind
      if (target_tick == '0 || (now64 > target_tick && now64 - target_tick > iv * 2))
        target_tick = now64 + half;
      rel         = target_tick;
      target_tick = target_tick + iv;
      release_q.push_back('{paced: 1'b1, release_time: rel[TIME_W-1:0]});
    endfunction

    function void report(string what, out_res_t want, out_res_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected paced=%0b release=%0d, got paced=%0b release=%0d",
                 $time, what, want.paced, want.release_time, got.paced, got.release_time);
    endfunction

    function void check_result(out_res_t got);
      out_res_t want;
      if (release_q.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      want = release_q.pop_front();
      if (got.paced !== want.paced)
        report("paced", want, got);
      if (got.release_time !== want.release_time)
        report("release_time", want, got);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  in_req_t              in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_res_t             out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  release_scoreboard    sb;
  bit                   calm;
  bit                   hold_req;
  int                   cycle_count;
  int                   sent;
  logic [TIME_W-1:0]    tick_cursor;
  logic                 rec_state;

  frame_pacing_release_timer DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(out_data);
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [63:0] wide_rand();
    return {$urandom, $urandom};
  endfunction

  task automatic send_request(in_req_t req);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_request(req);
    sent++;
  endtask

  task automatic send_frame(logic [TIME_W-1:0] now, logic rec);
    send_request('{mode: MODE_FRAME, time_now: now, recording: rec});
  endtask

  task automatic send_timing_reset();
    send_request('{mode: MODE_RESET, time_now: TIME_W'(wide_rand()),
                   recording: 1'($urandom_range(0, 1))});
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.release_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_settings(pacing_cfg_t s);
    drain_results();
    write_reg(CFG_TIMER_FREQ,   CFG_W'(s.freq));
    write_reg(CFG_SYNC_ENABLE,  CFG_W'(s.sync_en));
    write_reg(CFG_CAPTURE_RATE, CFG_W'(s.cap_rate));
    write_reg(CFG_RATE_MULT,    CFG_W'(s.mult));
    write_reg(CFG_GENERAL_EN,   CFG_W'(s.gen_en));
    write_reg(CFG_GENERAL_RATE, CFG_W'(s.gen_rate));
    cfg_we <= 1'b0;
    sb.cfg = s;
  endtask

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return RATE_W'(1);
      2:       return RATE_W'(1000);
      3:       return RATE_W'($urandom_range(0, 1000));
      default: return RATE_W'($urandom_range(24, 240));
    endcase
  endfunction

  function automatic pacing_cfg_t random_settings();
    pacing_cfg_t s;
    case ($urandom_range(0, 5))
      0:       s.freq = 32'd1;
      1:       s.freq = 32'hFFFF_FFFF;
      2:       s.freq = $urandom;
      3:       s.freq = FREQ_W'($urandom_range(1, 20000));
      default: s.freq = TIMER_FREQ_RST;
    endcase
    s.sync_en  = ($urandom_range(0, 3) != 0);
    s.cap_rate = pick_rate();
    s.mult     = ($urandom_range(0, 4) == 0) ? MULT_W'($urandom_range(0, 15))
                                             : MULT_W'($urandom_range(1, 8));
    s.gen_en   = ($urandom_range(0, 4) != 0);
    s.gen_rate = pick_rate();
    return s;
  endfunction

  // Mostly on cadence with jitter; sometimes late, early, repeated or far off.
  function automatic logic [TIME_W-1:0] next_tick(logic rec);
    logic [63:0] iv, spread, base;
    logic        active;
    int          pick;
    iv = sb.frame_interval(rec, active);
    if (!active || iv == '0)
      iv = 64'($urandom_range(1, 1000));
    spread = iv / 2 + 1;
    base   = {1'b0, tick_cursor};
    pick   = $urandom_range(0, 99);
    if (pick < 65)
      base = base + iv - iv / 4 + wide_rand() % spread;
    else if (pick < 75)
      base = base + iv * 64'($urandom_range(2, 5)) + wide_rand() % spread;
    else if (pick < 82)
      base = base - wide_rand() % (iv * 2);
    else if (pick < 89)
      base = wide_rand();
    else if (pick < 94)
      base = {1'b0, TICK_MAX} - wide_rand() % (iv * 3);
    tick_cursor = base[TIME_W-1:0];
    return tick_cursor;
  endfunction

  task automatic random_traffic(int count);
    repeat (count) begin
      if ($urandom_range(0, 9) == 0)
        rec_state = ~rec_state;
      if ($urandom_range(0, 19) == 0)
        send_timing_reset();
      else
        send_frame(next_tick(rec_state), rec_state);
    end
  endtask

  initial begin
    pacing_cfg_t s;
    logic [63:0] iv, t;
    logic        act;
    int          phase_no;
    int          count;

    sb          = new();
    tick_cursor = '0;
    rec_state   = 1'b0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: limiter off, release immediately
    send_frame('0, 1'b0);
    send_frame(TICK_MAX, 1'b1);
    send_timing_reset();
    send_frame(TIME_W'(123456789), 1'b0);

    // general limit: arm, cadence, early, lag at and past two intervals, reset event
    s = CFG_DEFAULTS;
    s.gen_en   = 1'b1;
    s.gen_rate = RATE_W'(60);
    apply_settings(s);
    iv = sb.frame_interval(1'b0, act);
    send_frame(TIME_W'(1000), 1'b0);
    send_frame(sb.target_tick[TIME_W-1:0], 1'b0);
    t = sb.target_tick - 1000;
    send_frame(t[TIME_W-1:0], 1'b0);
    t = sb.target_tick + iv * 2;
    send_frame(t[TIME_W-1:0], 1'b0);
    t = sb.target_tick + iv * 2 + 1;
    send_frame(t[TIME_W-1:0], 1'b0);
    send_timing_reset();
    send_frame(t[TIME_W-1:0], 1'b0);
    t = t + iv;
    send_frame(t[TIME_W-1:0], 1'b1);    // recording without sync stays on general

    // widest settings; target crosses the top of the tick range
    s = '{freq: 32'hFFFF_FFFF, sync_en: 1'b1, cap_rate: RATE_W'(1000), mult: MULT_MAX,
          gen_en: 1'b1, gen_rate: RATE_W'(1000)};
    apply_settings(s);
    send_frame(TICK_MAX - TIME_W'(100), 1'b1);
    send_frame(TICK_MAX - TIME_W'(50), 1'b1);
    send_frame(TICK_MAX, 1'b0);         // interval change re-arms
    send_frame(TICK_MAX, 1'b1);

    // capture path invalid while recording
    s = '{freq: TIMER_FREQ_RST, sync_en: 1'b1, cap_rate: '0, mult: MULT_W'(1),
          gen_en: 1'b1, gen_rate: RATE_W'(60)};
    apply_settings(s);
    send_frame(TIME_W'(5000), 1'b1);
    send_frame(TIME_W'(6000), 1'b0);
    s.cap_rate = RATE_W'(30);
    s.mult     = '0;
    apply_settings(s);
    send_frame(TIME_W'(7000), 1'b1);
    s.mult = '1;
    apply_settings(s);
    send_frame(TIME_W'(8000), 1'b1);

    // zero interval: half step is one tick
    s = '{freq: 32'd1, sync_en: 1'b0, cap_rate: '0, mult: MULT_W'(1),
          gen_en: 1'b1, gen_rate: RATE_W'(1000)};
    apply_settings(s);
    send_frame(TIME_W'(5), 1'b0);
    send_frame(TIME_W'(5), 1'b0);
    send_frame(TIME_W'(6), 1'b0);
    send_frame(TIME_W'(100), 1'b0);
    tick_cursor = TIME_W'(100);

    phase_no = 0;
    while (sent < ITEM_TARGET - 250) begin
      phase_no++;
      apply_settings(random_settings());
      count = $urandom_range(80, 130);
      if (phase_no == 2)
        hold_req = 1'b1;     // result side holds off while requests pile up
      if (phase_no == 4) begin
        random_traffic(count / 2);
        drain_results();     // sender waits for every pending result
        random_traffic(count - count / 2);
      end else begin
        random_traffic(count);
      end
    end

    // last stretch: no idling on either side
    s = random_settings();
    s.gen_en   = 1'b1;
    s.gen_rate = RATE_W'($urandom_range(24, 240));
    apply_settings(s);
    calm = 1'b1;
    random_traffic(ITEM_TARGET - sent);
    drain_results();

    if (sb.mismatches == 0 && sb.release_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
